>>> src/lslc_pkg.sv
package lslc_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned LuxW   = 17;
  localparam int unsigned ChW    = 22;
  localparam int unsigned CoefW  = 10;
  localparam int unsigned SegN   = 7;
  localparam int unsigned FifoDepth = 2;

  localparam logic [LuxW-1:0] ClipLux = 17'd65536;

  typedef enum logic [1:0] {
    IT_13MS  = 2'd0,
    IT_101MS = 2'd1,
    IT_402MS = 2'd2,
    IT_SPARE = 2'd3
  } itime_e;

  typedef enum logic [1:0] {
    REG_ITIME = 2'd0,
    REG_GAIN  = 2'd1,
    REG_PKG   = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_e;

  // word handed from the front end to the back end
  typedef struct packed {
    logic          clipped;
    logic          pkg;
    logic [ChW-1:0] ch0;
    logic [ChW-1:0] ch1;
  } entry_t;

  typedef struct packed {
    itime_e itime;
    logic   gain_high;
    logic   pkg;
  } cfg_t;

  function automatic logic [CoefW-1:0] seg_k(input logic pkg, input logic [2:0] i);
    logic [CoefW-1:0] r;
    r = '0;
    if (!pkg) begin
      case (i)
        3'd0: r = 10'h040; 3'd1: r = 10'h080; 3'd2: r = 10'h0c0; 3'd3: r = 10'h100;
        3'd4: r = 10'h138; 3'd5: r = 10'h19a; 3'd6: r = 10'h29a; default: r = '0;
      endcase
    end else begin
      case (i)
        3'd0: r = 10'h043; 3'd1: r = 10'h085; 3'd2: r = 10'h0c8; 3'd3: r = 10'h10a;
        3'd4: r = 10'h14d; 3'd5: r = 10'h19a; 3'd6: r = 10'h29a; default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [CoefW-1:0] seg_b(input logic pkg, input logic [2:0] i);
    logic [CoefW-1:0] r;
    r = '0;
    if (!pkg) begin
      case (i)
        3'd0: r = 10'h1f2; 3'd1: r = 10'h214; 3'd2: r = 10'h23f; 3'd3: r = 10'h270;
        3'd4: r = 10'h16f; 3'd5: r = 10'h0d2; 3'd6: r = 10'h018; default: r = '0;
      endcase
    end else begin
      case (i)
        3'd0: r = 10'h204; 3'd1: r = 10'h228; 3'd2: r = 10'h253; 3'd3: r = 10'h282;
        3'd4: r = 10'h177; 3'd5: r = 10'h101; 3'd6: r = 10'h037; default: r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [CoefW-1:0] seg_m(input logic pkg, input logic [2:0] i);
    logic [CoefW-1:0] r;
    r = '0;
    if (!pkg) begin
      case (i)
        3'd0: r = 10'h1be; 3'd1: r = 10'h2d1; 3'd2: r = 10'h37b; 3'd3: r = 10'h3fe;
        3'd4: r = 10'h1fc; 3'd5: r = 10'h0fb; 3'd6: r = 10'h012; default: r = '0;
      endcase
    end else begin
      case (i)
        3'd0: r = 10'h1ad; 3'd1: r = 10'h2c1; 3'd2: r = 10'h363; 3'd3: r = 10'h3df;
        3'd4: r = 10'h1dd; 3'd5: r = 10'h127; 3'd6: r = 10'h02b; default: r = '0;
      endcase
    end
    return r;
  endfunction

endpackage

>>> src/lslc_in_if.sv
interface lslc_in_if;
  logic                          valid;
  logic                          ready;
  logic [lslc_pkg::CountW-1:0]   broadband_count;
  logic [lslc_pkg::CountW-1:0]   infrared_count;
  modport source (output valid, broadband_count, infrared_count, input ready);
  modport sink   (input valid, broadband_count, infrared_count, output ready);
endinterface

>>> src/lslc_out_if.sv
interface lslc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lslc_pkg::LuxW-1:0]   lux;
  logic                        clipped;
  modport source (output valid, lux, clipped, input ready);
  modport sink   (input valid, lux, clipped, output ready);
endinterface

>>> src/lslc_front.sv
module lslc_front (
  input  lslc_pkg::cfg_t              cfg_i,
  input  logic [lslc_pkg::CountW-1:0] bb_i,
  input  logic [lslc_pkg::CountW-1:0] ir_i,
  output lslc_pkg::entry_t            entry_o
);
  logic [15:0] clip;
  logic [18:0] scale;
  logic [34:0] p0, p1;

  always_comb begin
    unique case (cfg_i.itime)
      lslc_pkg::IT_13MS:  begin clip = 16'd4900;  scale = 19'h07517; end
      lslc_pkg::IT_101MS: begin clip = 16'd37000; scale = 19'h00fe7; end
      default:            begin clip = 16'd65000; scale = 19'h00400; end
    endcase
    if (!cfg_i.gain_high) scale = scale << 4;
    p0 = 35'(bb_i) * 35'(scale);
    p1 = 35'(ir_i) * 35'(scale);
    entry_o.clipped = (bb_i > clip) || (ir_i > clip);
    entry_o.pkg     = cfg_i.pkg;
    // below the clip threshold the products fit in 32 bits
    entry_o.ch0     = p0[31:10];
    entry_o.ch1     = p1[31:10];
  end
endmodule

>>> src/lslc_fifo.sv
module lslc_fifo #(
  parameter int unsigned Depth = lslc_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lslc_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lslc_pkg::entry_t rdata_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lslc_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end
endmodule

>>> src/lslc_back.sv
module lslc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       avail_i,
  input  lslc_pkg::entry_t           entry_i,
  output logic                       pop_o,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic [lslc_pkg::LuxW-1:0]  lux_o,
  output logic                       clipped_o
);
  localparam int unsigned ChW = lslc_pkg::ChW;
  localparam int unsigned CoefW = lslc_pkg::CoefW;

  logic en;
  logic a_vld_q, b_vld_q, o_vld_q;

  // stage A: segment choice and coefficient lookup
  logic            a_clip_q;
  logic [ChW-1:0]  a_ch0_q, a_ch1_q;
  logic [CoefW-1:0] a_b_q, a_m_q;
  // stage B: products
  logic            b_clip_q;
  logic [31:0]     b_t0_q, b_t1_q;
  logic [lslc_pkg::LuxW-1:0] lux_q;
  logic            clip_q;

  logic [2:0]  seg;
  logic [31:0] ir_shift;
  logic [32:0] lim;
  logic [32:0] diff;

  assign en    = !o_vld_q || ready_i;
  assign pop_o = avail_i && en;

  // rounded ratio <= k  <=>  ch1*1024 < (2k+1)*ch0
  always_comb begin
    ir_shift = {entry_i.ch1[ChW-1:0], 10'b0};
    seg = 3'd7;
    lim = '0;
    for (int i = lslc_pkg::SegN - 1; i >= 0; i--) begin
      lim = 33'(entry_i.ch0) *
            33'({lslc_pkg::seg_k(entry_i.pkg, 3'(i)), 1'b1});
      if (33'(ir_shift) < lim) seg = 3'(i);
    end
    if (entry_i.ch0 == '0) seg = 3'd0;
  end

  always_comb begin
    diff = (b_t0_q > b_t1_q) ? 33'(b_t0_q - b_t1_q) : '0;
    diff = diff + 33'(1 << 13);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_clip_q <= entry_i.clipped;
      a_ch0_q  <= entry_i.ch0;
      a_ch1_q  <= entry_i.ch1;
      a_b_q    <= lslc_pkg::seg_b(entry_i.pkg, seg);
      a_m_q    <= lslc_pkg::seg_m(entry_i.pkg, seg);
      b_clip_q <= a_clip_q;
      b_t0_q   <= 32'(a_ch0_q * 32'(a_b_q));
      b_t1_q   <= 32'(a_ch1_q * 32'(a_m_q));
      clip_q   <= b_clip_q;
      lux_q    <= b_clip_q ? lslc_pkg::ClipLux : diff[30:14];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= avail_i;
      b_vld_q <= a_vld_q;
      o_vld_q <= b_vld_q;
    end
  end

  assign valid_o   = o_vld_q;
  assign lux_o     = lux_q;
  assign clipped_o = clip_q;
endmodule

>>> src/light_sensor_lux_calc_top.sv
// Lux calculator for a two-channel (broadband + infrared) light sensor. One count pair
// is taken per clock when the output is drained; each result passes from its accepted pair
// through front scaling into a two-word queue, then segment lookup, products and
// rounding in a three-stage back end. Throughput is one word per cycle while the output
// is ready, set by the back-end pipeline. Registers at 0x0 integration time, 0x4 gain,
// 0x8 package table; write them only while idle.
module light_sensor_lux_calc_top #(
  parameter int unsigned FifoDepth = lslc_pkg::FifoDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lslc_in_if.sink     in_ch,
  lslc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  lslc_pkg::cfg_t   cfg_q;
  lslc_pkg::entry_t f_entry, q_entry;
  logic full, empty, pop;
  lslc_pkg::reg_idx_e idx;
  logic wr;

  assign pready = 1'b1;
  assign idx    = lslc_pkg::reg_idx_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.itime     <= lslc_pkg::IT_402MS;
      cfg_q.gain_high <= 1'b0;
      cfg_q.pkg       <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        lslc_pkg::REG_ITIME: cfg_q.itime     <= lslc_pkg::itime_e'(pwdata[1:0]);
        lslc_pkg::REG_GAIN:  cfg_q.gain_high <= pwdata[0];
        lslc_pkg::REG_PKG:   cfg_q.pkg       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lslc_pkg::REG_ITIME: prdata = {30'b0, cfg_q.itime};
      lslc_pkg::REG_GAIN:  prdata = {31'b0, cfg_q.gain_high};
      lslc_pkg::REG_PKG:   prdata = {31'b0, cfg_q.pkg};
      default:             prdata = '0;
    endcase
  end

  assign in_ch.ready = !full;

  lslc_front u_front (
    .cfg_i   (cfg_q),
    .bb_i    (in_ch.broadband_count),
    .ir_i    (in_ch.infrared_count),
    .entry_o (f_entry)
  );

  lslc_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_ch.valid && !full),
    .wdata_i (f_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (q_entry)
  );

  lslc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .avail_i   (!empty),
    .entry_i   (q_entry),
    .pop_o     (pop),
    .valid_o   (out_ch.valid),
    .ready_i   (out_ch.ready),
    .lux_o     (out_ch.lux),
    .clipped_o (out_ch.clipped)
  );

  // words in flight: queue plus three back-end stages
  logic [3:0] inflight_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inflight_q <= '0;
    else inflight_q <= inflight_q + 4'(in_ch.valid && in_ch.ready)
                                  - 4'(out_ch.valid && out_ch.ready);
  end

  a_clip_lux: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.clipped |-> out_ch.lux == lslc_pkg::ClipLux)
    else $error("clipped word without clip value");

  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 4'(FifoDepth + 3))
    else $error("more words in flight than storage");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> inflight_q != '0)
    else $error("output word with nothing accepted");
endmodule

>>> verif/light_sensor_lux_calc_top_tb.sv
module light_sensor_lux_calc_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [lslc_pkg::LuxW-1:0] lux;
    logic                      clipped;
  } lux_word_t;

  class lux_scoreboard;
    lux_word_t pending[$];
    int        errors;
    logic [1:0] itime;
    logic       gain;
    logic       pkg;
    logic [9:0] tk[2][7];
    logic [9:0] tb[2][8];
    logic [9:0] tm[2][8];

    function new();
      errors = 0;
      itime = lslc_pkg::IT_402MS;
      gain = 1'b0;
      pkg = 1'b0;
      tk = '{'{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
             '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}};
      tb = '{'{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
             '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}};
      tm = '{'{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
             '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}};
    endfunction

    function void note_pair(logic [15:0] bb, logic [15:0] ir);
      lux_word_t w;
      logic [63:0] thr, scale, ch0, ch1, ratio, t0, t1, diff;
      int seg;
      case (itime)
        lslc_pkg::IT_13MS: begin thr = 4900; scale = 64'h7517; end
        lslc_pkg::IT_101MS: begin thr = 37000; scale = 64'h0fe7; end
        default: begin thr = 65000; scale = 64'd1024; end
      endcase
      if (bb > thr || ir > thr) begin
        w.lux = lslc_pkg::ClipLux;
        w.clipped = 1'b1;
      end else begin
        if (!gain) scale = scale << 4;
        ch0 = (bb * scale) >> 10;
        ch1 = (ir * scale) >> 10;
        ratio = (ch0 != 0) ? (ch1 << 10) / ch0 : 0;
        ratio = (ratio + 1) >> 1;
        seg = 7;
        for (int i = 6; i >= 0; i--) if (ratio <= tk[pkg][i]) seg = i;
        t0 = ch0 * tb[pkg][seg];
        t1 = ch1 * tm[pkg][seg];
        diff = ((t0 > t1) ? t0 - t1 : 0) + 64'd8192;
        w.lux = diff[30:14];
        w.clipped = 1'b0;
      end
      pending.push_back(w);
    endfunction

    function void check_lux(logic [lslc_pkg::LuxW-1:0] lux, logic clipped);
      lux_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected word lux=%0d clipped=%0d", lux, clipped);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (lux !== w.lux) begin
        $error("lux: expected %0d, actual %0d", w.lux, lux);
        errors++;
      end
      if (clipped !== w.clipped) begin
        $error("clipped: expected %0d, actual %0d", w.clipped, clipped);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int cycles = 0;
  int hold_off = 0;
  bit stall_en = 1'b0;

  lslc_in_if in_ch();
  lslc_out_if out_ch();
  lux_scoreboard sb = new();

  light_sensor_lux_calc_top i_dut (
    .clk_i, .rst_ni, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.broadband_count = '0;
    in_ch.infrared_count = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("light_sensor_lux_calc_top_tb: FAIL");
      $finish;
    end
    if (rst_ni && in_ch.valid && in_ch.ready)
      sb.note_pair(in_ch.broadband_count, in_ch.infrared_count);
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_lux(out_ch.lux, out_ch.clipped);
  end

  // receiver: own stall pattern, plus a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_en) begin
      out_ch.ready <= (cycles % 11 < 3) ? ($urandom_range(0, 3) != 0) : 1'b1;
    end else begin
      out_ch.ready <= rst_ni;
    end
  end

  task automatic write_reg(lslc_pkg::reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      lslc_pkg::REG_ITIME: sb.itime = val[1:0];
      lslc_pkg::REG_GAIN: sb.gain = val[0];
      lslc_pkg::REG_PKG: sb.pkg = val[0];
      default: ;
    endcase
  endtask

  task automatic send_pair(logic [15:0] bb, logic [15:0] ir);
    in_ch.valid <= 1'b1;
    in_ch.broadband_count <= bb;
    in_ch.infrared_count <= ir;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic random_pair(logic [1:0] it);
    int thr;
    logic [15:0] bb, ir;
    thr = (it == lslc_pkg::IT_13MS) ? 4900 : (it == lslc_pkg::IT_101MS) ? 37000 : 65000;
    case ($urandom_range(0, 9))
      0: begin bb = 16'($urandom); ir = 16'($urandom); end
      1: begin bb = 16'($urandom_range(0, thr)); ir = 16'($urandom_range(0, 16)); end
      2: begin bb = '0; ir = 16'($urandom_range(0, thr)); end
      3: begin
        bb = 16'($urandom_range(thr - 3, thr + 3));
        ir = 16'($urandom_range(0, thr));
      end
      default: begin
        bb = 16'($urandom_range(0, thr));
        ir = 16'($urandom_range(0, bb));
      end
    endcase
    send_pair(bb, ir);
    // burst end: random gap
    if ($urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  initial begin
    logic [1:0] it;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // defaults after reset: 402 ms, 1x, first table
    send_pair(16'd0, 16'd0);
    send_pair(16'hffff, 16'd0);
    send_pair(16'd0, 16'hffff);
    send_pair(16'd65000, 16'd65000);
    send_pair(16'd65001, 16'd0);
    send_pair(16'd1000, 16'd100);
    send_pair(16'd1000, 16'd300);
    send_pair(16'd1000, 16'd450);
    send_pair(16'd1000, 16'd600);
    send_pair(16'd1000, 16'd1000);
    send_pair(16'd100, 16'd900);
    send_pair(16'haaaa, 16'h5555);
    send_pair(16'h5555, 16'h2aaa);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(lslc_pkg::REG_ITIME, 32'(lslc_pkg::IT_13MS));
    write_reg(lslc_pkg::REG_GAIN, 32'd1);
    write_reg(lslc_pkg::REG_PKG, 32'd1);
    send_pair(16'd4900, 16'd4900);
    send_pair(16'd4901, 16'd10);
    send_pair(16'd4000, 16'd1);
    send_pair(16'd1, 16'd0);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(lslc_pkg::REG_ITIME, 32'(lslc_pkg::IT_SPARE));
    send_pair(16'd65000, 16'd200);
    send_pair(16'd65001, 16'd200);
    in_ch.valid <= 1'b0;
    drain();
    stall_en = 1'b1;
    for (int ph = 0; ph < 16; ph++) begin
      it = 2'(ph % 4);
      write_reg(lslc_pkg::REG_ITIME, {30'd0, it});
      write_reg(lslc_pkg::REG_GAIN, 32'((ph / 4) % 2));
      write_reg(lslc_pkg::REG_PKG, 32'(ph / 8));
      if (ph == 5) hold_off = 60;
      for (int n = 0; n < 105; n++) random_pair(it);
      in_ch.valid <= 1'b0;
      drain();
    end
    if (sb.errors == 0) begin
      $display("light_sensor_lux_calc_top_tb: PASS");
    end else begin
      $display("light_sensor_lux_calc_top_tb: FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/lslc_pkg.sv
src/lslc_in_if.sv
src/lslc_out_if.sv
src/lslc_front.sv
src/lslc_fifo.sv
src/lslc_back.sv
src/light_sensor_lux_calc_top.sv
verif/light_sensor_lux_calc_top_tb.sv
